// File: hdl/ctf_pkg.sv
// ctf_pkg: shared types, register codes, reset values and constants for the
// complementary tilt filter. No dependencies.
package ctf_pkg;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_LSB    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_LSB     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIBRATED   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_BASE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VIB_BASE     = 3'd5;

   localparam logic [15:0] ALPHA_RST     = 16'd64225;
   localparam logic [15:0] ACCEL_LSB_RST = 16'd16384;
   localparam logic [15:0] GYRO_LSB_RST  = 16'd1310;

   // 5.8 * 9.81 in Q16
   localparam logic [21:0] VIB_K = 22'd3728867;
   // 981 squared, for the 0.1 m/s^2 magnitude threshold
   localparam logic [19:0] THR_K = 20'd962361;

   localparam int PRESCALE   = 14;
   localparam int ATAN_W     = 23;
   localparam int CORDIC_MAX = 24;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;

   typedef struct packed {
      logic [15:0] filter_alpha;
      logic [15:0] accel_lsb;
      logic [15:0] gyro_lsb;
      logic        calibrated;
      logic [14:0] tilt_base;
      logic [14:0] vib_base;
   } cfg_type;

   typedef struct packed {
      logic [31:0]        sum;
      logic [31:0]        sxz;
      logic [31:0]        syz;
      logic signed [15:0] ay;
      logic signed [16:0] nax;
      logic signed [15:0] gx;
      logic signed [15:0] gy;
      logic [6:0]         dt;
      logic               first;
      logic               sub;
      logic               thr;
   } q_entry_type;

   function automatic logic [15:0] fix_zero(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   // atan(2^-i) in Q16 degrees
   function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] idx);
      logic [ATAN_W-1:0] r;
      case (idx)
         5'd0:  r = 23'd2949120;
         5'd1:  r = 23'd1740967;
         5'd2:  r = 23'd919879;
         5'd3:  r = 23'd466945;
         5'd4:  r = 23'd234379;
         5'd5:  r = 23'd117304;
         5'd6:  r = 23'd58666;
         5'd7:  r = 23'd29335;
         5'd8:  r = 23'd14668;
         5'd9:  r = 23'd7334;
         5'd10: r = 23'd3667;
         5'd11: r = 23'd1833;
         5'd12: r = 23'd917;
         5'd13: r = 23'd458;
         5'd14: r = 23'd229;
         5'd15: r = 23'd115;
         5'd16: r = 23'd57;
         5'd17: r = 23'd29;
         5'd18: r = 23'd14;
         5'd19: r = 23'd7;
         5'd20: r = 23'd4;
         5'd21: r = 23'd2;
         5'd22: r = 23'd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/ctf_if.sv
// ctf_if: valid/ready channel interfaces for samples, results and register
// writes of the complementary tilt filter. No dependencies.
interface ctf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic [15:0]        elapsed_ms;
   logic               restart;
   logic               subtract_baseline;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms,
                   restart, subtract_baseline, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms,
                 restart, subtract_baseline, output ready);
endinterface

interface ctf_rsp_if;
   logic               valid;
   logic               ready;
   logic [14:0]        tilt;
   logic [14:0]        vibration;
   logic signed [15:0] angle_x;
   logic signed [15:0] angle_y;

   modport source (output valid, tilt, vibration, angle_x, angle_y, input ready);
   modport sink (input valid, tilt, vibration, angle_x, angle_y, output ready);
endinterface

interface ctf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/ctf_front.sv
// ctf_front: accepts samples, forms squared axes, the magnitude threshold and
// the first-sample flag, and pushes one queue entry per beat. Uses ctf_pkg, ctf_if.
module ctf_front import ctf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   ctf_req_if.sink     req,
   output logic        push_valid,
   input  logic        push_ready,
   output q_entry_type push_data
);

   logic s1_valid_ff, s2_valid_ff, have_prev_ff;
   logic adv1, adv2, accept;

   logic [31:0]        sxx_ff, syy_ff, szz_ff;
   logic signed [15:0] ay_ff, gx_ff, gy_ff;
   logic signed [16:0] nax_ff;
   logic [6:0]         dt_ff;
   logic               first_ff, sub_ff;

   logic signed [31:0] pxx, pyy, pzz;
   logic [6:0]         dt_in;
   logic [15:0]        alsb;

   q_entry_type        s2_ff;
   logic [51:0]        lhs;
   logic [51:0]        rhs;
   logic [31:0]        lsb2_ff;

   assign adv2      = !s2_valid_ff || push_ready;
   assign adv1      = !s1_valid_ff || adv2;
   assign req.ready = adv1;
   assign accept    = req.valid && adv1;
   assign alsb      = fix_zero(cfg.accel_lsb);

   assign pxx = req.accel_x * req.accel_x;
   assign pyy = req.accel_y * req.accel_y;
   assign pzz = req.accel_z * req.accel_z;

   always_comb begin
      if (req.elapsed_ms == 16'd0) begin
         dt_in = 7'd1;
      end else if (req.elapsed_ms > 16'd100) begin
         dt_in = 7'd100;
      end else begin
         dt_in = req.elapsed_ms[6:0];
      end
   end

   // exact threshold: sum * 981^2 > 100 * lsb^2
   assign lhs = 52'(s2_ff.sum) * 52'(THR_K);
   assign rhs = 52'(lsb2_ff) * 52'd100;

   always_comb begin
      push_data     = s2_ff;
      push_data.thr = lhs > rhs;
   end
   assign push_valid = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req.valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (accept) begin
            have_prev_ff <= 1'b1;
         end
      end
      if (accept) begin
         sxx_ff   <= 32'(pxx);
         syy_ff   <= 32'(pyy);
         szz_ff   <= 32'(pzz);
         ay_ff    <= req.accel_y;
         nax_ff   <= 17'sd0 - 17'(req.accel_x);
         gx_ff    <= req.gyro_x;
         gy_ff    <= req.gyro_y;
         dt_ff    <= dt_in;
         first_ff <= req.restart || !have_prev_ff;
         sub_ff   <= req.subtract_baseline;
      end
      if (adv2 && s1_valid_ff) begin
         s2_ff.sum   <= sxx_ff + syy_ff + szz_ff;
         s2_ff.sxz   <= sxx_ff + szz_ff;
         s2_ff.syz   <= syy_ff + szz_ff;
         s2_ff.ay    <= ay_ff;
         s2_ff.nax   <= nax_ff;
         s2_ff.gx    <= gx_ff;
         s2_ff.gy    <= gy_ff;
         s2_ff.dt    <= dt_ff;
         s2_ff.first <= first_ff;
         s2_ff.sub   <= sub_ff;
         s2_ff.thr   <= 1'b0;
         lsb2_ff     <= 32'(alsb) * 32'(alsb);
      end
   end

endmodule

// File: hdl/ctf_queue.sv
// ctf_queue: two-entry queue that decouples the front end from the back end.
// Uses ctf_pkg.
module ctf_queue import ctf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  q_entry_type push_data,
   output logic        pop_valid,
   input  logic        pop,
   output q_entry_type pop_data
);

   q_entry_type        mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_W:0]   count_ff;
   logic               do_push, do_pop;

   assign push_ready = count_ff != (Q_PTR_W+1)'(Q_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/ctf_isqrt.sv
// ctf_isqrt: shared floor square root, one result bit per cycle.
// Depends on nothing.
module ctf_isqrt #(
   parameter int W = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   op,
   output logic           done,
   output logic [W/2-1:0] root
);

   localparam int H   = W / 2;
   localparam int CW  = $clog2(H + 1);

   logic [W-1:0]  op_ff;
   logic [H:0]    rem_ff;
   logic [H-1:0]  root_ff;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;

   // remainder can reach twice the root, so it carries one bit more
   logic [H+2:0]  rem_in;
   logic [H+1:0]  trial;
   logic          ge;

   assign rem_in = {rem_ff, op_ff[W-1:W-2]};
   assign trial  = {root_ff, 2'b01};
   assign ge     = rem_in >= (H+3)'(trial);
   assign done   = done_ff;
   assign root   = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && (cnt_ff == CW'(1));
         if (start) begin
            cnt_ff <= CW'(H);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (start) begin
         op_ff   <= op;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cnt_ff != '0) begin
         op_ff   <= op_ff << 2;
         rem_ff  <= (H+1)'(ge ? rem_in - (H+3)'(trial) : rem_in);
         root_ff <= {root_ff[H-2:0], ge};
      end
   end

endmodule

// File: hdl/ctf_back.sv
// ctf_back: per-entry sequencer for vibration, CORDIC angles, gyro fusion and
// tilt, with the result register. Uses ctf_pkg, ctf_if, ctf_isqrt.
module ctf_back import ctf_pkg::*; #(
   parameter int ANGLE_FRAC_BITS   = 8,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        pop_valid,
   output logic        pop,
   input  q_entry_type pop_data,
   ctf_rsp_if.source   rsp
);

   localparam int F      = ANGLE_FRAC_BITS;
   localparam int RSH    = 16 - F;
   localparam int N_IT   = (CORDIC_ITERATIONS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_ITERATIONS;
   localparam int SQ_W   = 64;
   localparam int RT_W   = SQ_W / 2;
   localparam int DIFF_W = 16 + F;
   localparam int VP_W   = DIFF_W + 23;
   localparam int DV_W   = 24 + F;
   localparam int DEN_W  = 23;
   localparam int DC_W   = $clog2(DV_W + 1);
   localparam int XY_W   = 33;
   localparam int Z_W    = 24;
   localparam int INC_W  = 17 + F;
   localparam int PI_W   = 18 + F;
   localparam int P1_W   = PI_W + 17;
   localparam int P2_W   = 42;
   localparam int S_W    = PI_W + 26;
   localparam int LIM_W  = 7 + F;
   localparam int T_W    = (LIM_W > 15) ? LIM_W : 15;
   localparam logic [LIM_W-1:0]     LIM   = LIM_W'(90 << F);
   localparam logic signed [Z_W-1:0] Z_RND = Z_W'((1 << RSH) >> 1);
   localparam logic signed [S_W-1:0] S_RND = S_W'(1 << 15);

   typedef enum logic [3:0] {
      S_IDLE, S_MAG, S_VMUL, S_VDIV, S_ASQRT, S_CORDIC, S_EST, S_GDIV,
      S_FMUL1, S_FMUL2, S_FSUM, S_TSQ, S_TSQRT, S_OUT
   } state_type;

   state_type state_ff;

   q_entry_type          e_ff;
   logic                 sq_start_ff, sq_done;
   logic [SQ_W-1:0]      sq_op_ff;
   logic [RT_W-1:0]      sq_root;
   logic [RT_W-1:0]      mag_ff;
   logic [T_W-1:0]       vib_ff;

   logic [DV_W-1:0]      div_num_ff, div_quo_ff;
   logic [DEN_W-1:0]     div_den_ff, div_rem_ff;
   logic [DC_W-1:0]      div_cnt_ff;
   logic                 g_neg_ff;

   logic signed [XY_W-1:0] cx_ff, cy_ff;
   logic signed [Z_W-1:0]  cz_ff, acc_r_ff, acc_p_ff;
   logic [4:0]             ci_ff;
   logic                   czero_ff, axis_ff;

   logic signed [INC_W-1:0] inc_ff;
   logic signed [P1_W-1:0]  p1_ff;
   logic signed [P2_W-1:0]  p2_ff;
   logic signed [15:0]      est_r_ff, est_p_ff;

   logic                 out_valid_ff;
   logic [14:0]          out_tilt_ff, out_vib_ff, res_tilt_ff, res_vib_ff;
   logic signed [15:0]   out_ax_ff, out_ay_ff;

   // combinational helpers
   logic [15:0]          alsb, glsb;
   logic [DIFF_W-1:0]    mag_w, one_w, diff;
   logic [VP_W-1:0]      vprod;
   logic [DEN_W:0]       div_r;
   logic                 div_ge;
   logic [15:0]          gx_abs, gy_abs;
   logic [DEN_W-1:0]     g_den;
   logic signed [16:0]   y_raw;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  at, zr;
   logic signed [INC_W-1:0] inc_mag;
   logic signed [15:0]   prev_sel;
   logic signed [Z_W-1:0] acc_sel;
   logic signed [PI_W-1:0] pi_v;
   logic [16:0]          c_alpha;
   logic signed [S_W-1:0] fsum;
   logic signed [31:0]   rr, pp;
   logic [T_W-1:0]       tilt_lim, vib_lim;
   logic                 pop_any;

   function automatic logic signed [15:0] sat16(input logic signed [S_W-1:0] v);
      if (v > S_W'(32767)) begin
         return 16'sh7fff;
      end else if (v < -S_W'(32768)) begin
         return -16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic logic [14:0] finish(input logic [T_W-1:0] v, input logic [14:0] base,
                                          input logic sub_en);
      logic [T_W-1:0] r;
      r = v;
      if (sub_en) begin
         r = (v > T_W'(base)) ? v - T_W'(base) : '0;
      end
      return (r > T_W'(15'h7fff)) ? 15'h7fff : r[14:0];
   endfunction

   ctf_isqrt #(.W(SQ_W)) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start_ff),
      .op    (sq_op_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign alsb = fix_zero(cfg.accel_lsb);
   assign glsb = fix_zero(cfg.gyro_lsb);

   assign pop_any = (state_ff == S_IDLE) && pop_valid;
   assign pop     = pop_any;

   // vibration numerator
   assign mag_w = DIFF_W'(mag_ff);
   assign one_w = DIFF_W'(alsb) << F;
   assign diff  = (mag_w > one_w) ? mag_w - one_w : one_w - mag_w;
   assign vprod = VP_W'(diff) * VP_W'(VIB_K) + (VP_W'(alsb) << 15);

   // restoring divider step
   assign div_r  = {div_rem_ff, div_num_ff[DV_W-1]};
   assign div_ge = div_r >= {1'b0, div_den_ff};

   // gyro increment operands, magnitudes kept unsigned
   assign gx_abs  = 16'(e_ff.gx[15] ? -(17'(e_ff.gx)) : 17'(e_ff.gx));
   assign gy_abs  = 16'(e_ff.gy[15] ? -(17'(e_ff.gy)) : 17'(e_ff.gy));
   assign g_den   = DEN_W'(glsb) * DEN_W'(100);
   assign inc_mag = INC_W'(div_quo_ff);

   // cordic step
   assign y_raw = axis_ff ? e_ff.nax : 17'(e_ff.ay);
   assign xs    = cx_ff >>> ci_ff;
   assign ys    = cy_ff >>> ci_ff;
   assign at    = $signed(Z_W'(atan_deg(ci_ff)));
   assign zr    = (cz_ff + Z_RND) >>> RSH;

   // fusion
   assign prev_sel = axis_ff ? est_p_ff : est_r_ff;
   assign acc_sel  = axis_ff ? acc_p_ff : acc_r_ff;
   assign pi_v     = PI_W'(prev_sel) + PI_W'(inc_ff);
   assign c_alpha  = 17'h10000 - 17'(cfg.filter_alpha);
   assign fsum     = S_W'(p1_ff) + S_W'(p2_ff) + S_RND;

   // tilt
   assign rr = est_r_ff * est_r_ff;
   assign pp = est_p_ff * est_p_ff;
   assign tilt_lim = (sq_root > RT_W'(LIM)) ? T_W'(LIM) : T_W'(sq_root);
   assign vib_lim  = (div_quo_ff > DV_W'(LIM)) ? T_W'(LIM) : T_W'(div_quo_ff);

   assign rsp.valid     = out_valid_ff;
   assign rsp.tilt      = out_tilt_ff;
   assign rsp.vibration = out_vib_ff;
   assign rsp.angle_x   = out_ax_ff;
   assign rsp.angle_y   = out_ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sq_start_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
         axis_ff      <= 1'b0;
         est_r_ff     <= '0;
         est_p_ff     <= '0;
      end else begin
         if (out_valid_ff && rsp.ready && state_ff != S_OUT) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop_any) begin
                  e_ff        <= pop_data;
                  sq_op_ff    <= SQ_W'(pop_data.sum) << (2 * F);
                  sq_start_ff <= 1'b1;
                  state_ff    <= S_MAG;
               end
            end
            S_MAG: begin
               sq_start_ff <= 1'b0;
               if (sq_done) begin
                  mag_ff   <= sq_root;
                  state_ff <= S_VMUL;
               end
            end
            S_VMUL: begin
               div_num_ff <= DV_W'(vprod >> 16);
               div_den_ff <= DEN_W'(alsb);
               div_rem_ff <= '0;
               div_cnt_ff <= DC_W'(DV_W);
               state_ff   <= S_VDIV;
            end
            S_VDIV: begin
               if (div_cnt_ff != '0) begin
                  div_cnt_ff <= div_cnt_ff - 1'b1;
                  div_num_ff <= div_num_ff << 1;
                  div_rem_ff <= DEN_W'(div_ge ? div_r - {1'b0, div_den_ff} : div_r);
                  div_quo_ff <= {div_quo_ff[DV_W-2:0], div_ge};
               end else begin
                  vib_ff <= vib_lim;
                  if (e_ff.thr) begin
                     axis_ff     <= 1'b0;
                     sq_op_ff    <= SQ_W'(e_ff.sxz) << (2 * PRESCALE);
                     sq_start_ff <= 1'b1;
                     state_ff    <= S_ASQRT;
                  end else begin
                     acc_r_ff <= '0;
                     acc_p_ff <= '0;
                     state_ff <= S_EST;
                  end
               end
            end
            S_ASQRT: begin
               sq_start_ff <= 1'b0;
               if (sq_done) begin
                  cx_ff    <= $signed(XY_W'(sq_root));
                  cy_ff    <= XY_W'(y_raw) <<< PRESCALE;
                  cz_ff    <= '0;
                  ci_ff    <= '0;
                  czero_ff <= (sq_root == '0) && (y_raw == '0);
                  state_ff <= S_CORDIC;
               end
            end
            S_CORDIC: begin
               if (ci_ff != 5'(N_IT)) begin
                  if (cy_ff > 0) begin
                     cx_ff <= cx_ff + ys;
                     cy_ff <= cy_ff - xs;
                     cz_ff <= cz_ff + at;
                  end else begin
                     cx_ff <= cx_ff - ys;
                     cy_ff <= cy_ff + xs;
                     cz_ff <= cz_ff - at;
                  end
                  ci_ff <= ci_ff + 1'b1;
               end else if (!axis_ff) begin
                  acc_r_ff    <= czero_ff ? '0 : zr;
                  axis_ff     <= 1'b1;
                  sq_op_ff    <= SQ_W'(e_ff.syz) << (2 * PRESCALE);
                  sq_start_ff <= 1'b1;
                  state_ff    <= S_ASQRT;
               end else begin
                  acc_p_ff <= czero_ff ? '0 : zr;
                  state_ff <= S_EST;
               end
            end
            S_EST: begin
               if (e_ff.first) begin
                  est_r_ff <= sat16(S_W'(acc_r_ff));
                  est_p_ff <= sat16(S_W'(acc_p_ff));
                  state_ff <= S_TSQ;
               end else begin
                  axis_ff    <= 1'b0;
                  g_neg_ff   <= e_ff.gx[15];
                  div_num_ff <= (DV_W'(23'(gx_abs) * 23'(e_ff.dt)) << F)
                                + DV_W'(g_den >> 1);
                  div_den_ff <= g_den;
                  div_rem_ff <= '0;
                  div_cnt_ff <= DC_W'(DV_W);
                  state_ff   <= S_GDIV;
               end
            end
            S_GDIV: begin
               if (div_cnt_ff != '0) begin
                  div_cnt_ff <= div_cnt_ff - 1'b1;
                  div_num_ff <= div_num_ff << 1;
                  div_rem_ff <= DEN_W'(div_ge ? div_r - {1'b0, div_den_ff} : div_r);
                  div_quo_ff <= {div_quo_ff[DV_W-2:0], div_ge};
               end else begin
                  inc_ff   <= g_neg_ff ? -inc_mag : inc_mag;
                  state_ff <= S_FMUL1;
               end
            end
            S_FMUL1: begin
               p1_ff    <= $signed({1'b0, cfg.filter_alpha}) * pi_v;
               state_ff <= S_FMUL2;
            end
            S_FMUL2: begin
               p2_ff    <= $signed({1'b0, c_alpha}) * acc_sel;
               state_ff <= S_FSUM;
            end
            S_FSUM: begin
               if (!axis_ff) begin
                  est_r_ff   <= sat16(fsum >>> 16);
                  axis_ff    <= 1'b1;
                  g_neg_ff   <= e_ff.gy[15];
                  div_num_ff <= (DV_W'(23'(gy_abs) * 23'(e_ff.dt)) << F)
                                + DV_W'(g_den >> 1);
                  div_den_ff <= g_den;
                  div_rem_ff <= '0;
                  div_cnt_ff <= DC_W'(DV_W);
                  state_ff   <= S_GDIV;
               end else begin
                  est_p_ff <= sat16(fsum >>> 16);
                  state_ff <= S_TSQ;
               end
            end
            S_TSQ: begin
               sq_op_ff    <= SQ_W'($unsigned(rr)) + SQ_W'($unsigned(pp));
               sq_start_ff <= 1'b1;
               state_ff    <= S_TSQRT;
            end
            S_TSQRT: begin
               sq_start_ff <= 1'b0;
               if (sq_done) begin
                  res_tilt_ff <= finish(tilt_lim, cfg.tilt_base, e_ff.sub && cfg.calibrated);
                  res_vib_ff  <= finish(vib_ff, cfg.vib_base, e_ff.sub && cfg.calibrated);
                  state_ff    <= S_OUT;
               end
            end
            S_OUT: begin
               if (!out_valid_ff || rsp.ready) begin
                  out_valid_ff <= 1'b1;
                  out_tilt_ff  <= res_tilt_ff;
                  out_vib_ff   <= res_vib_ff;
                  out_ax_ff    <= est_r_ff;
                  out_ay_ff    <= est_p_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_sqrt_done_expected: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == S_MAG || state_ff == S_ASQRT || state_ff == S_TSQRT))
      else $error("square root finished outside a waiting state");

   a_vib_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EST || state_ff == S_TSQ) |-> (vib_ff <= T_W'(LIM)))
      else $error("vibration above clamp");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result beat raised outside output state");

endmodule

// File: hdl/complementary_tilt_filter.sv
// complementary_tilt_filter: top level with register file, front end, queue and
// back end. Uses ctf_pkg, ctf_if, ctf_front, ctf_queue, ctf_back.
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   accel_x/y/z, gyro_x/y, elapsed_ms, restart, subtract_baseline
//   rsp_ch   out  valid/ready   tilt, vibration, angle_x, angle_y
//   csr_ch   in   valid/ready   index, data (ready always high)
//
// the front end takes a beat every cycle while the queue has room, into a
// two-entry queue; the back end pops a beat only when idle, and its pace is set by
// the bit-per-cycle square root and divider and the cordic steps
// synchronous active-high reset; estimates restart from the next sample
// a stalled result holds in the output register while the next beat computes
module complementary_tilt_filter import ctf_pkg::*; #(
   parameter int ANGLE_FRAC_BITS   = 8,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic     clock,
   input  logic     reset,
   ctf_req_if.sink  req_ch,
   ctf_rsp_if.source rsp_ch,
   ctf_csr_if.sink  csr_ch
);

   cfg_type     cfg_ff;
   logic        push_valid, push_ready, pop_valid, pop;
   q_entry_type push_data, pop_data;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_alpha <= ALPHA_RST;
         cfg_ff.accel_lsb    <= ACCEL_LSB_RST;
         cfg_ff.gyro_lsb     <= GYRO_LSB_RST;
         cfg_ff.calibrated   <= 1'b0;
         cfg_ff.tilt_base    <= '0;
         cfg_ff.vib_base     <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FILTER_ALPHA: cfg_ff.filter_alpha <= csr_ch.data;
            CSR_ACCEL_LSB:    cfg_ff.accel_lsb    <= csr_ch.data;
            CSR_GYRO_LSB:     cfg_ff.gyro_lsb     <= csr_ch.data;
            CSR_CALIBRATED:   cfg_ff.calibrated   <= csr_ch.data[0];
            CSR_TILT_BASE:    cfg_ff.tilt_base    <= csr_ch.data[14:0];
            CSR_VIB_BASE:     cfg_ff.vib_base     <= csr_ch.data[14:0];
            default: begin
            end
         endcase
      end
   end

   ctf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ctf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   ctf_back #(
      .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS),
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_data  (pop_data),
      .rsp       (rsp_ch)
   );

endmodule

// File: verif/testbench.sv
// testbench: self-checking bench for complementary_tilt_filter, driving raw imu
// samples and register writes and checking every result against a predictor.
// Depends on hdl/ctf_pkg.sv, hdl/ctf_if.sv and the rtl of the filter.
module testbench;
   import ctf_pkg::*;

   localparam int FRAC      = 8;
   localparam int CORDIC_N  = 16;
   localparam int LATENCY   = 400;
   localparam longint TILT_MAX = 90 << FRAC;

   typedef struct {
      logic signed [15:0] ax, ay, az, gx, gy;
      logic [15:0]        ms;
      bit                 restart, sub;
   } imu_sample_type;

   typedef struct {
      logic [14:0]        tilt, vib;
      logic signed [15:0] roll, pitch;
   } tilt_result_type;

   typedef struct {
      logic [2:0]  idx;
      logic [15:0] data;
   } reg_write_type;

   const longint atan_q16[24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   logic clock;
   logic reset;

   ctf_req_if req_bus();
   ctf_rsp_if rsp_bus();
   ctf_csr_if csr_bus();

   complementary_tilt_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   imu_sample_type  sample_q[$];
   tilt_result_type expected_q[$];
   reg_write_type   reg_q[$];

   // predictor copy of registers and filter state
   longint cf_alpha, cf_alsb, cf_glsb, cf_cal, cf_tbase, cf_vbase;
   longint est_roll, est_pitch;
   bit     primed;

   int errors;
   int n_samples;
   int n_results;
   int n_writes;
   bit burst;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic longint isqrt(longint n);
      longint r;
      longint b;
      r = 0;
      b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // atan2(y, sqrt(sq)) in degrees with FRAC fraction bits
   function automatic longint accel_angle(longint y_raw, longint sq);
      longint x, y, z, xs, ys;
      x = isqrt(sq << 28);
      y = y_raw * 16384;
      z = 0;
      if (x == 0 && y == 0) return 0;
      for (int i = 0; i < CORDIC_N; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_q16[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_q16[i];
         end
      end
      return (z + (longint'(1) << (15 - FRAC))) >>> (16 - FRAC);
   endfunction

   function automatic longint gyro_step(longint g, longint dt, longint glsb);
      longint m, den, q;
      m = (g < 0 ? -g : g) * dt * (longint'(1) << FRAC);
      den = 100 * glsb;
      q = (m + den / 2) / den;
      return g < 0 ? -q : q;
   endfunction

   function automatic longint blend(longint prev, longint inc, longint acc);
      longint s;
      s = cf_alpha * (prev + inc) + (65536 - cf_alpha) * acc;
      return sat16((s + 32768) >>> 16);
   endfunction

   // advances the filter state by one sample and returns the expected result
   function automatic tilt_result_type predict_tilt(imu_sample_type s);
      tilt_result_type r;
      longint ax, ay, az, alsb, glsb, sxx, syy, szz, sum;
      longint mag, one, diff, vib, tilt, acc_r, acc_p, dt;
      ax = s.ax; ay = s.ay; az = s.az;
      alsb = cf_alsb == 0 ? 1 : cf_alsb;
      glsb = cf_glsb == 0 ? 1 : cf_glsb;
      sxx = ax * ax; syy = ay * ay; szz = az * az;
      sum = sxx + syy + szz;
      mag = isqrt(sum << (2 * FRAC));
      one = alsb << FRAC;
      diff = mag > one ? mag - one : one - mag;
      vib = (diff * 3728867 + (alsb << 15)) / (alsb << 16);
      if (vib > TILT_MAX) vib = TILT_MAX;
      acc_r = 0;
      acc_p = 0;
      if (sum * 962361 > 100 * alsb * alsb) begin
         acc_r = accel_angle(ay, sxx + szz);
         acc_p = accel_angle(-ax, syy + szz);
      end
      if (!primed || s.restart) begin
         est_roll = sat16(acc_r);
         est_pitch = sat16(acc_p);
      end else begin
         dt = s.ms;
         if (dt < 1) dt = 1;
         if (dt > 100) dt = 100;
         est_roll = blend(est_roll, gyro_step(s.gx, dt, glsb), acc_r);
         est_pitch = blend(est_pitch, gyro_step(s.gy, dt, glsb), acc_p);
      end
      primed = 1'b1;
      tilt = isqrt(est_roll * est_roll + est_pitch * est_pitch);
      if (tilt > TILT_MAX) tilt = TILT_MAX;
      if (s.sub && cf_cal != 0) begin
         tilt = tilt > cf_tbase ? tilt - cf_tbase : 0;
         vib = vib > cf_vbase ? vib - cf_vbase : 0;
      end
      r.tilt = tilt[14:0];
      r.vib = vib[14:0];
      r.roll = est_roll[15:0];
      r.pitch = est_pitch[15:0];
      return r;
   endfunction

   function automatic int draw_wait();
      return burst ? 0 : $urandom_range(0, 19);
   endfunction

   // register writes
   always @(posedge clock) begin
      reg_write_type w;
      if (reset) begin
         csr_bus.valid <= 1'b0;
         cf_alpha <= ALPHA_RST;
         cf_alsb <= ACCEL_LSB_RST;
         cf_glsb <= GYRO_LSB_RST;
         cf_cal <= 0;
         cf_tbase <= 0;
         cf_vbase <= 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_FILTER_ALPHA: cf_alpha <= csr_bus.data;
               CSR_ACCEL_LSB:    cf_alsb <= csr_bus.data;
               CSR_GYRO_LSB:     cf_glsb <= csr_bus.data;
               CSR_CALIBRATED:   cf_cal <= csr_bus.data[0];
               CSR_TILT_BASE:    cf_tbase <= csr_bus.data[14:0];
               CSR_VIB_BASE:     cf_vbase <= csr_bus.data[14:0];
               default: ;
            endcase
            n_writes++;
         end
         if (!csr_bus.valid || csr_bus.ready) begin
            if (reg_q.size() != 0) begin
               w = reg_q.pop_front();
               csr_bus.index <= w.idx;
               csr_bus.data <= w.data;
               csr_bus.valid <= 1'b1;
            end else begin
               csr_bus.valid <= 1'b0;
            end
         end
      end
   end

   // sample driver
   imu_sample_type in_flight;
   int req_gap;

   always @(posedge clock) begin
      imu_sample_type s;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap <= 0;
         primed = 1'b0;
         est_roll = 0;
         est_pitch = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_q.push_back(predict_tilt(in_flight));
            n_samples++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (sample_q.size() != 0 && reg_q.size() == 0 && !csr_bus.valid) begin
               // register writes land before the next sample goes out
               s = sample_q.pop_front();
               in_flight = s;
               req_bus.accel_x <= s.ax;
               req_bus.accel_y <= s.ay;
               req_bus.accel_z <= s.az;
               req_bus.gyro_x <= s.gx;
               req_bus.gyro_y <= s.gy;
               req_bus.elapsed_ms <= s.ms;
               req_bus.restart <= s.restart;
               req_bus.subtract_baseline <= s.sub;
               req_bus.valid <= 1'b1;
               req_gap <= draw_wait();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   int rsp_hold;

   always @(posedge clock) begin
      tilt_result_type e;
      int d;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         n_results++;
         if (expected_q.size() == 0) begin
            $display("%0t: result with none expected: tilt %0d vib %0d x %0d y %0d",
                     $time, rsp_bus.tilt, rsp_bus.vibration, rsp_bus.angle_x,
                     rsp_bus.angle_y);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_bus.tilt !== e.tilt) begin
               $display("%0t: tilt expected %0d got %0d", $time, e.tilt, rsp_bus.tilt);
               errors++;
            end
            if (rsp_bus.vibration !== e.vib) begin
               $display("%0t: vibration expected %0d got %0d", $time, e.vib,
                        rsp_bus.vibration);
               errors++;
            end
            if (rsp_bus.angle_x !== e.roll) begin
               $display("%0t: angle_x expected %0d got %0d", $time, e.roll,
                        rsp_bus.angle_x);
               errors++;
            end
            if (rsp_bus.angle_y !== e.pitch) begin
               $display("%0t: angle_y expected %0d got %0d", $time, e.pitch,
                        rsp_bus.angle_y);
               errors++;
            end
         end
         d = draw_wait();
         rsp_hold <= d;
         rsp_bus.ready <= (d == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_bus.ready <= (rsp_hold == 1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic add_sample(int ax, int ay, int az, int gx, int gy, int ms,
                             bit rs, bit sb);
      imu_sample_type s;
      s.ax = ax; s.ay = ay; s.az = az; s.gx = gx; s.gy = gy;
      s.ms = ms; s.restart = rs; s.sub = sb;
      sample_q.push_back(s);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      reg_write_type w;
      w.idx = idx;
      w.data = data;
      reg_q.push_back(w);
   endtask

   // one accel axis near the current scale, with some full-range noise
   function automatic int rand_axis(longint lsb);
      longint v;
      if ($urandom_range(0, 4) == 0) return $signed(16'($urandom));
      v = longint'($urandom_range(0, 2 * (lsb + 8))) - (lsb + 8);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return int'(v);
   endfunction

   task automatic add_random(int n, longint lsb);
      int ms;
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) burst = ($urandom_range(0, 3) == 0);
         ms = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 120);
         add_sample(rand_axis(lsb), rand_axis(lsb), rand_axis(lsb),
                    $signed(16'($urandom)), $signed(16'($urandom)), ms,
                    $urandom_range(0, 15) == 0, $urandom_range(0, 1));
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_bus.valid || expected_q.size() != 0 ||
             reg_q.size() != 0 || csr_bus.valid);
      repeat (LATENCY) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.accel_x = '0;
      req_bus.accel_y = '0;
      req_bus.accel_z = '0;
      req_bus.gyro_x = '0;
      req_bus.gyro_y = '0;
      req_bus.elapsed_ms = '0;
      req_bus.restart = 1'b0;
      req_bus.subtract_baseline = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      errors = 0;
      n_samples = 0;
      n_results = 0;
      n_writes = 0;
      burst = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset registers
      add_sample(0, 0, 0, 0, 0, 0, 0, 0);
      add_sample(0, 0, 16384, 0, 0, 10, 0, 0);
      add_sample(32767, 32767, 32767, 32767, 32767, 65535, 0, 1);
      add_sample(-32768, -32768, -32768, -32768, -32768, 0, 0, 0);
      add_sample(16384, 0, 0, 1000, -1000, 1, 0, 0);
      add_sample(0, -16384, 0, -1000, 1000, 100, 0, 0);
      add_sample(0, 16384, 0, 500, 500, 101, 0, 0);
      add_sample(1, 0, 0, 0, 0, 50, 0, 0);
      add_sample(-32768, 0, 0, 32767, -32768, 100, 0, 0);
      add_sample(0, 0, -16384, 0, 0, 20, 1, 0);
      add_sample(11585, 11585, 0, 200, -200, 5, 0, 1);
      add_sample(0, 0, 0, 32767, 32767, 100, 0, 0);
      add_sample(-16384, 16384, 16384, -32768, -32768, 65535, 0, 0);
      add_sample(0, 0, 16384, 0, 0, 10, 1, 1);
      add_random(140, 16384);
      wait_idle();

      // zero accel scale, slowest gyro, full baselines
      write_reg(CSR_FILTER_ALPHA, 16'd0);
      write_reg(CSR_ACCEL_LSB, 16'd0);
      write_reg(CSR_GYRO_LSB, 16'd65535);
      write_reg(CSR_CALIBRATED, 16'd1);
      write_reg(CSR_TILT_BASE, 16'd23040);
      write_reg(CSR_VIB_BASE, 16'd23040);
      add_sample(0, 0, 1, 0, 0, 10, 0, 1);
      add_random(100, 1);
      wait_idle();

      write_reg(CSR_FILTER_ALPHA, 16'd65535);
      write_reg(CSR_ACCEL_LSB, 16'd32768);
      write_reg(CSR_GYRO_LSB, 16'd0);
      write_reg(CSR_TILT_BASE, 16'hffff);
      write_reg(CSR_VIB_BASE, 16'd0);
      add_random(100, 32768);
      wait_idle();

      write_reg(CSR_FILTER_ALPHA, 16'($urandom));
      write_reg(CSR_ACCEL_LSB, 16'($urandom_range(1, 32768)));
      write_reg(CSR_GYRO_LSB, 16'($urandom_range(1, 65535)));
      write_reg(CSR_TILT_BASE, 16'($urandom_range(0, 3000)));
      write_reg(CSR_VIB_BASE, 16'($urandom_range(0, 3000)));
      add_random(200, 4096);
      wait_idle();

      write_reg(CSR_FILTER_ALPHA, ALPHA_RST);
      write_reg(CSR_ACCEL_LSB, ACCEL_LSB_RST);
      write_reg(CSR_GYRO_LSB, GYRO_LSB_RST);
      write_reg(CSR_CALIBRATED, 16'd0);
      add_random(200, 16384);
      wait_idle();

      $display("covered %0d samples over five register settings, %0d register writes",
               n_samples, n_writes);
      $display("%0d results checked, %0d mismatches", n_results, errors);
      if (errors == 0) begin
         $display("complementary_tilt_filter verification clean");
      end else begin
         $display("complementary_tilt_filter verification failed");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("complementary_tilt_filter verification failed");
      $finish;
   end

endmodule
